// File: rtl/f2h_pkg.sv
// Shared types and constants for the single precision to 16-bit converter.
// No dependencies; imported by f2h_convert and fp32_to_half_converter.
package f2h_pkg;

    typedef enum logic
    {
        FMT_HALF = 1'b0,
        FMT_BF16 = 1'b1
    } fmt_t;

    localparam int SINGLE_W = 32;
    localparam int HALF_W   = 16;

    localparam logic [15:0] SIGN_BIT16   = 16'h8000;
    localparam logic [15:0] HALF_INF     = 16'h7c00;

    // Single exponent thresholds, with e = exp - 112 in half terms
    localparam logic [7:0]  EXP_REBIAS   = 8'd112;  // e == 0
    localparam logic [7:0]  EXP_UNDER    = 8'd102;  // e == -10
    localparam logic [7:0]  EXP_OVER     = 8'd143;  // e == 31
    localparam logic [7:0]  DENORM_SHIFT = 8'd126;  // shift = 14 - e

endpackage

// File: rtl/fp32_to_half_converter.sv
// Top level of the single precision to half / bfloat16 stream converter.
// Depends on f2h_pkg and f2h_convert.
//
// Converts one 32-bit IEEE single pattern per transaction into a 16-bit
// pattern, IEEE half (target_format 0) or bfloat16 (target_format 1). The
// block accepts one transaction every cycle unless the output is stalled; an
// input register feeds the conversion logic, which feeds the output register.
// Half mode rounds by adding the first dropped bit, turns overflow, infinity
// and NaN into signed infinity, and flushes tiny values to signed zero. Write
// target_format only while no transaction is in flight.
module fp32_to_half_converter
    import f2h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SINGLE_W-1:0] s_axis_tdata,   // [31:0] single_bits
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [HALF_W-1:0]   m_axis_tdata    // [15:0] half_bits
);

    fmt_t                target_format_reg;
    logic                s1_valid_reg;
    logic [SINGLE_W-1:0] s1_data_reg;
    logic                out_valid_reg;
    logic [HALF_W-1:0]   out_data_reg;
    logic [HALF_W-1:0]   conv_result;
    logic                out_ready;
    logic                s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_format_reg <= FMT_HALF;
        end
        else if (cfg_wr_en)
        begin
            target_format_reg <= fmt_t'(cfg_wr_data);
        end
    end

    // Each stage advances when the one after it is empty or draining
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || out_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_data_reg <= s_axis_tdata;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_data_reg <= conv_result;
        end
    end

    f2h_convert u_convert
    (
        .single_bits   (s1_data_reg),
        .target_format (target_format_reg),
        .half_bits     (conv_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A stalled input stage keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("input stage lost or changed a stalled transaction");

    // A transaction leaving the input stage shows up at the output
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_ready) |=> m_axis_tvalid)
        else $error("transaction dropped between stages");

    // The output register only loads the converted value of the input stage
    a_out_value: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_ready) |=> (m_axis_tdata == $past(conv_result)))
        else $error("output register does not match conversion");

endmodule

// File: rtl/f2h_convert.sv
// Combinational conversion of one single precision pattern to half or bfloat16.
// Depends on f2h_pkg for the format type and exponent thresholds.
module f2h_convert
    import f2h_pkg::*;
(
    input  logic [SINGLE_W-1:0] single_bits,
    input  fmt_t                target_format,
    output logic [HALF_W-1:0]   half_bits
);

    logic [15:0] sign;
    logic [7:0]  exp8;
    logic [22:0] mant;
    logic [23:0] mant_full;
    logic [7:0]  shift_wide;
    logic [4:0]  shift;
    logic [4:0]  shift_m1;
    logic [23:0] denorm_shifted;
    logic        denorm_round;
    logic [15:0] denorm_res;
    logic [7:0]  exp_diff;
    logic [15:0] normal_res;
    logic [15:0] half_res;
    logic [15:0] bf16_res;

    assign sign      = {single_bits[31], 15'd0};
    assign exp8      = single_bits[30:23];
    assign mant      = single_bits[22:0];
    assign mant_full = {1'b1, mant};

    // Denormal range: shift the mantissa with hidden bit by 14..24
    assign shift_wide     = DENORM_SHIFT - exp8;
    assign shift          = shift_wide[4:0];
    assign shift_m1       = shift - 5'd1;
    assign denorm_shifted = mant_full >> shift;
    assign denorm_round   = mant_full[shift_m1];
    assign denorm_res     = sign | (denorm_shifted[15:0] + {15'd0, denorm_round});

    // Normal range: rebias, drop 13 bits, add the first dropped bit
    assign exp_diff   = exp8 - EXP_REBIAS;
    assign normal_res = (sign | {1'b0, exp_diff[4:0], mant[22:13]}) + {15'd0, mant[12]};

    always_comb
    begin
        if (exp8 < EXP_UNDER)
        begin
            half_res = sign;
        end
        else if (exp8 <= EXP_REBIAS)
        begin
            half_res = denorm_res;
        end
        else if (exp8 >= EXP_OVER)
        begin
            half_res = sign | HALF_INF;
        end
        else
        begin
            half_res = normal_res;
        end
    end

    // Adding 0x8000 and keeping the top half wraps at the word boundary
    assign bf16_res = single_bits[31:16] + {15'd0, single_bits[15]};

    always_comb
    begin
        unique case (target_format)
            FMT_HALF: half_bits = half_res;
            FMT_BF16: half_bits = bf16_res;
            default:  half_bits = half_res;
        endcase
    end

endmodule
